[rtl/ors_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_pkg
// Types and constants shared by the rectangle search block.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int MaxRows  = 256;
  localparam int MaxCols  = 256;
  localparam int RowW     = $clog2(MaxRows);
  localparam int ColW     = $clog2(MaxCols);
  localparam int AddrW    = RowW + ColW;
  localparam int CfgW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int ScoreW   = 48;

  localparam logic [CfgIdxW-1:0] RegMixWeight  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinWidth   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLeftLimit  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRightStart = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTopCap     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStep       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRowsUsed   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegColsUsed   = 3'd7;

  localparam logic signed [ScoreW-1:0] ScoreInit = {1'b0, {(ScoreW-1){1'b1}}};

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] unary_cum;
    logic signed [31:0] vert_pair_cum;
    logic signed [31:0] horiz_pair_cum;
    logic [8:0]         upper_bound;
    logic [8:0]         lower_bound;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [8:0] left_col;
    logic [8:0] top_row;
    logic [8:0] right_col;
    logic       found;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] mix_weight;
    logic [7:0]  min_width;
    logic [8:0]  left_limit;
    logic [7:0]  right_start;
    logic [8:0]  top_cap;
    logic [7:0]  step;
    logic [8:0]  rows_used;
    logic [8:0]  cols_used;
  } cfg_t;

  // command passed from front to back
  typedef struct packed {
    logic             wr_tab;
    logic             wr_bnd;
    logic [AddrW-1:0] addr;
    logic [ColW-1:0]  col;
    logic signed [31:0] unary;
    logic signed [31:0] vert;
    logic signed [31:0] horiz;
    logic [8:0]       ub;
    logic [8:0]       lb;
    logic             search;
  } cmd_t;

endpackage

[rtl/optimal_rectangle_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optimal_rectangle_search
// Loads cost tables and bounds, then searches for the best rectangle.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) each write one table cell; at row 0 the
// column bounds are written too. Load beats go through a two-entry queue and
// are taken at one per cycle while no search runs. A beat with last set
// starts the search; the queue takes at most two more beats, then the input
// side stalls until the result is registered.
// Search: per (left, right) pair, a bound scan reads each column, then each
// top row in range is read, multiplied, summed and compared, or skipped; the
// walk is sequential over one multiply stage and one table read port pair.
// One result beat appears on out_valid/out_stall after each last beat; it
// holds while stalled.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Synchronous reset clears control and restores
// register defaults; table contents are kept undefined until loaded.
// ----------------------------------------------------------------------------
module optimal_rectangle_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ors_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ors_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ors_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ors_pkg::out_beat_t          out_data
);
  ors_pkg::cfg_t cfg;
  ors_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;

  ors_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);

  ors_front u_front (.clk, .rst, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd);

  ors_back u_back (.clk, .rst, .cfg, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data);
endmodule

[rtl/ors_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ors_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/ors_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_front
// Accepts load beats, classifies them and fills a two-entry command queue.
// ----------------------------------------------------------------------------
module ors_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ors_pkg::in_beat_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output ors_pkg::cmd_t    cmd
);
  ors_pkg::cmd_t q [2];
  logic [1:0]    count;
  logic          rd_ptr;
  logic          wr_ptr;
  ors_pkg::cmd_t c;
  logic          push;
  logic          pop;

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_comb begin
    c        = '0;
    c.wr_tab = 1'b1;
    c.wr_bnd = (in_data.row == 8'd0);
    c.addr   = {in_data.col, in_data.row};
    c.col    = in_data.col;
    c.unary  = in_data.unary_cum;
    c.vert   = in_data.vert_pair_cum;
    c.horiz  = in_data.horiz_pair_cum;
    c.ub     = in_data.upper_bound;
    c.lb     = in_data.lower_bound;
    c.search = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= c;
    end
    if (rst) begin
      count  <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/ors_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_back
// Writes tables and bounds, then walks the candidates that the configuration selects and keeps the best.
// ----------------------------------------------------------------------------
module ors_back (
  input  logic              clk,
  input  logic              rst,
  input  ors_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  ors_pkg::cmd_t     cmd,
  output logic              out_valid,
  input  logic              out_stall,
  output ors_pkg::out_beat_t out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_LINIT, S_RINIT, S_BND_RD, S_BND_WAIT, S_BND_ACC, S_TINIT,
    S_TRD, S_TWAIT, S_MUL, S_SUM, S_CMP, S_TNEXT, S_RNEXT, S_OUT
  } state_t;

  state_t state;

  localparam int AW = ors_pkg::AddrW;
  localparam int CW = ors_pkg::ColW;

  logic [9:0]  l, r, c, t, tmax;
  logic [9:0]  st, h, w;
  logic [16:0] lam;
  logic [8:0]  mn, mx;
  logic        found;
  logic signed [ors_pkg::ScoreW-1:0] best;
  logic [8:0]  bl, bt, br;

  logic [AW-1:0] raddr_a, raddr_b;
  logic [CW-1:0] braddr;
  logic signed [31:0] ua, ub_, va, vb, ha, hb;
  logic [8:0]  upr, lwr;
  logic signed [33:0] u, p;
  logic signed [51:0] m1, m2;
  logic signed [52:0] s;
  logic signed [ors_pkg::ScoreW-1:0] score;
  logic        busy;
  logic        tab_we, bnd_we;

  assign busy     = (state != S_IDLE);
  assign cmd_take = !busy;
  assign tab_we   = cmd_valid && !busy && cmd.wr_tab;
  assign bnd_we   = cmd_valid && !busy && cmd.wr_bnd;
  assign braddr   = c[CW-1:0];

  ors_ram #(.Width(32), .Depth(1 << AW)) u_ua (.clk, .we(tab_we), .waddr(cmd.addr),
    .wdata(cmd.unary), .raddr(raddr_a), .rdata(ua));
  ors_ram #(.Width(32), .Depth(1 << AW)) u_ub (.clk, .we(tab_we), .waddr(cmd.addr),
    .wdata(cmd.unary), .raddr(raddr_b), .rdata(ub_));
  ors_ram #(.Width(32), .Depth(1 << AW)) u_va (.clk, .we(tab_we), .waddr(cmd.addr),
    .wdata(cmd.vert), .raddr(raddr_a), .rdata(va));
  ors_ram #(.Width(32), .Depth(1 << AW)) u_vb (.clk, .we(tab_we), .waddr(cmd.addr),
    .wdata(cmd.vert), .raddr(raddr_b), .rdata(vb));
  ors_ram #(.Width(32), .Depth(1 << AW)) u_ha (.clk, .we(tab_we), .waddr(cmd.addr),
    .wdata(cmd.horiz), .raddr(raddr_a), .rdata(ha));
  ors_ram #(.Width(32), .Depth(1 << AW)) u_hb (.clk, .we(tab_we), .waddr(cmd.addr),
    .wdata(cmd.horiz), .raddr(raddr_b), .rdata(hb));
  ors_ram #(.Width(9), .Depth(1 << CW)) u_up (.clk, .we(bnd_we), .waddr(cmd.col),
    .wdata(cmd.ub), .raddr(braddr), .rdata(upr));
  ors_ram #(.Width(9), .Depth(1 << CW)) u_lo (.clk, .we(bnd_we), .waddr(cmd.col),
    .wdata(cmd.lb), .raddr(braddr), .rdata(lwr));

  assign raddr_a = {l[CW-1:0], t[7:0]};
  assign raddr_b = {r[CW-1:0], t[7:0]};
  assign s       = 53'(m1) + 53'(m2);
  assign score   = ors_pkg::ScoreW'(s >>> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.search) begin
            lam   <= (cfg.mix_weight > 16'd32768) ? 17'd32768 : {1'b0, cfg.mix_weight};
            h     <= (cfg.rows_used > 9'd256) ? 10'd256 : {1'b0, cfg.rows_used};
            w     <= (cfg.cols_used > 9'd256) ? 10'd256 : {1'b0, cfg.cols_used};
            st    <= (cfg.step == 8'd0) ? 10'd1 : {2'b0, cfg.step};
            best  <= ors_pkg::ScoreInit;
            found <= 1'b0;
            bl    <= '1;
            bt    <= '1;
            br    <= '1;
            l     <= '0;
            state <= S_LINIT;
          end
        end
        S_LINIT: begin
          if (l < {1'b0, cfg.left_limit} && l < w) begin
            state <= S_RINIT;
          end else begin
            state <= S_OUT;
          end
        end
        S_RINIT: begin
          if ({2'b0, cfg.right_start} > l + {2'b0, cfg.min_width}) begin
            r <= {2'b0, cfg.right_start};
          end else begin
            r <= l + {2'b0, cfg.min_width};
          end
          state <= S_RNEXT;
        end
        S_RNEXT: begin
          if (r < w) begin
            c     <= l;
            state <= S_BND_RD;
          end else begin
            l     <= l + st;
            state <= S_LINIT;
          end
        end
        S_BND_RD: state <= S_BND_WAIT;
        S_BND_WAIT: begin
          if (c == l || upr < mn) mn <= upr;
          if (c == l || lwr > mx) mx <= lwr;
          state <= S_BND_ACC;
        end
        S_BND_ACC: begin
          if (c == r) begin
            state <= S_TINIT;
          end else begin
            c     <= c + 10'd1;
            state <= S_BND_RD;
          end
        end
        S_TINIT: begin
          t     <= {1'b0, mn} - 10'd1;
          tmax  <= ((cfg.top_cap < mx) ? {1'b0, cfg.top_cap} : {1'b0, mx}) - 10'd1;
          state <= S_TNEXT;
        end
        S_TNEXT: begin
          // t all ones is the row above the table; tmax all ones means no rows
          if (tmax[9] || (t != '1 && t > tmax)) begin
            r     <= r + st;
            state <= S_RNEXT;
          end else if (t == '1 || t >= h) begin
            t <= t + st;
          end else begin
            state <= S_TRD;
          end
        end
        S_TRD: state <= S_TWAIT;
        S_TWAIT: begin
          u     <= 34'(ub_) - 34'(ua);
          p     <= 34'(vb) - 34'(va) + 34'(ha) + 34'(hb);
          state <= S_MUL;
        end
        S_MUL: begin
          m1    <= u * $signed({1'b0, 17'd32768 - lam});
          m2    <= p * $signed({1'b0, lam});
          state <= S_SUM;
        end
        S_SUM: state <= S_CMP;
        S_CMP: begin
          found <= 1'b1;
          if (score < best) begin
            best <= score;
            bl   <= l[8:0];
            bt   <= t[8:0];
            br   <= r[8:0];
          end
          t     <= t + st;
          state <= S_TNEXT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.found     <= found;
            out_data.left_col  <= found ? bl + 9'd1 : '0;
            out_data.top_row   <= found ? bt + 9'd1 : '0;
            out_data.right_col <= found ? br + 9'd1 : '0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
    end
  end
endmodule

[rtl/ors_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module ors_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ors_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ors_pkg::CfgW-1:0]      cfg_data,
  output ors_pkg::cfg_t                 cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mix_weight  <= 16'd16384;
      cfg.min_width   <= 8'd0;
      cfg.left_limit  <= 9'd256;
      cfg.right_start <= 8'd0;
      cfg.top_cap     <= 9'd256;
      cfg.step        <= 8'd1;
      cfg.rows_used   <= 9'd256;
      cfg.cols_used   <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ors_pkg::RegMixWeight:  cfg.mix_weight  <= cfg_data;
        ors_pkg::RegMinWidth:   cfg.min_width   <= cfg_data[7:0];
        ors_pkg::RegLeftLimit:  cfg.left_limit  <= cfg_data[8:0];
        ors_pkg::RegRightStart: cfg.right_start <= cfg_data[7:0];
        ors_pkg::RegTopCap:     cfg.top_cap     <= cfg_data[8:0];
        ors_pkg::RegStep:       cfg.step        <= cfg_data[7:0];
        ors_pkg::RegRowsUsed:   cfg.rows_used   <= cfg_data[8:0];
        ors_pkg::RegColsUsed:   cfg.cols_used   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end
endmodule

[rtl/ors_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ors_checker
// Port-level checks for the rectangle search block.
// ----------------------------------------------------------------------------
module ors_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input ors_pkg::out_beat_t  out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.left_col == 9'd0
      && out_data.top_row == 9'd0 && out_data.right_col == 9'd0)
    else $error("fields set without a candidate");

  a_some: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.left_col != 9'd0
      && out_data.right_col != 9'd0 && out_data.top_row != 9'd0)
    else $error("found result with empty field");
endmodule

bind optimal_rectangle_search ors_checker u_ors_checker (.clk, .rst, .out_valid,
  .out_stall, .out_data);
